FILE: rtl/core/aes_pkg.sv
// Package for the AES block encryption core: payload structs, control codes,
// S-box and GF(2^8) helpers. No dependencies.
package aes_pkg;

  typedef struct packed {
    logic [63:0] block_high;
    logic [63:0] block_low;
  } aes_in_t;

  typedef struct packed {
    logic [63:0] cipher_high;
    logic [63:0] cipher_low;
  } aes_out_t;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } aes_state_t;

  typedef enum logic [1:0] {
    RND_KEY,
    RND_FULL,
    RND_LAST
  } aes_rnd_op_t;

  localparam logic [2:0] REG_KEY_SIZE = 3'd0;
  localparam logic [2:0] REG_KEY_W0   = 3'd1;
  localparam logic [2:0] REG_KEY_W1   = 3'd2;
  localparam logic [2:0] REG_KEY_W2   = 3'd3;
  localparam logic [2:0] REG_KEY_W3   = 3'd4;

  localparam logic [1:0] KS_128 = 2'd0;
  localparam logic [1:0] KS_192 = 2'd1;
  localparam logic [1:0] KS_256 = 2'd2;

  localparam logic [7:0] SBOX [0:255] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] xtime(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

endpackage

FILE: rtl/core/aes_ksched.sv
// On-the-fly key schedule: four schedule words (one round key) per advance.
// Depends on aes_pkg.
module aes_ksched import aes_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        init,
  input  logic        adv,
  input  logic [3:0]  nk,
  input  logic [31:0] key_w [0:7],
  output logic [127:0] rk
);

  logic [31:0] win_r [0:7];
  logic [31:0] win_nxt [0:7];
  logic [5:0]  idx_r, idx_nxt;
  logic [3:0]  mod_r, mod_nxt;
  logic [7:0]  rcon_r, rcon_nxt;

  logic [31:0] bw [0:11];

  always_comb begin
    logic [3:0]  m;
    logic [7:0]  rc;
    logic [5:0]  idx;
    logic [31:0] t;
    logic [31:0] back;
    m  = mod_r;
    rc = rcon_r;
    for (int k = 0; k < 8; k++) bw[k] = win_r[k];
    for (int j = 0; j < 4; j++) begin
      idx = idx_r + 6'(j);
      case (nk)
        4'd4:    back = bw[4 + j];
        4'd6:    back = bw[2 + j];
        default: back = bw[j];
      endcase
      t = bw[7 + j];
      if (idx < {2'b00, nk}) begin
        bw[8 + j] = key_w[idx[2:0]];
      end else begin
        if (m == 4'd0) begin
          t  = sub_word({bw[7 + j][23:0], bw[7 + j][31:24]}) ^ {rc, 24'h0};
          rc = xtime(rc);
        end else if (nk == 4'd8 && m == 4'd4) begin
          t = sub_word(bw[7 + j]);
        end
        bw[8 + j] = back ^ t;
      end
      m = (m + 4'd1 == nk) ? 4'd0 : m + 4'd1;
    end
    for (int k = 0; k < 8; k++) win_nxt[k] = bw[k + 4];
    idx_nxt  = idx_r + 6'd4;
    mod_nxt  = m;
    rcon_nxt = rc;
  end

  assign rk = {bw[8], bw[9], bw[10], bw[11]};

  always_ff @(posedge clk) begin
    if (!rst_n || init) begin
      for (int k = 0; k < 8; k++) win_r[k] <= '0;
      idx_r  <= '0;
      mod_r  <= '0;
      rcon_r <= 8'h01;
    end else if (adv) begin
      win_r  <= win_nxt;
      idx_r  <= idx_nxt;
      mod_r  <= mod_nxt;
      rcon_r <= rcon_nxt;
    end
  end

endmodule

FILE: rtl/core/aes_round.sv
// Shared round unit: key add, full round or final round on the 128-bit state.
// Depends on aes_pkg.
module aes_round import aes_pkg::*; (
  input  aes_rnd_op_t  op,
  input  logic [127:0] s_in,
  input  logic [127:0] rk,
  output logic [127:0] s_out
);

  logic [7:0] sb [0:15];
  logic [7:0] ss [0:15];
  logic [7:0] mc [0:15];
  logic [127:0] ss_v, mc_v;

  always_comb begin
    logic [7:0] a0, a1, a2, a3, all;
    for (int n = 0; n < 16; n++) sb[n] = s_in[127 - 8*n -: 8];
    // combined SubBytes and ShiftRows
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        ss[4*c + r] = SBOX[sb[4*((c + r) % 4) + r]];
    for (int c = 0; c < 4; c++) begin
      a0  = ss[4*c];
      a1  = ss[4*c + 1];
      a2  = ss[4*c + 2];
      a3  = ss[4*c + 3];
      all = a0 ^ a1 ^ a2 ^ a3;
      mc[4*c]     = a0 ^ all ^ xtime(a0 ^ a1);
      mc[4*c + 1] = a1 ^ all ^ xtime(a1 ^ a2);
      mc[4*c + 2] = a2 ^ all ^ xtime(a2 ^ a3);
      mc[4*c + 3] = a3 ^ all ^ xtime(a3 ^ a0);
    end
    for (int n = 0; n < 16; n++) begin
      ss_v[127 - 8*n -: 8] = ss[n];
      mc_v[127 - 8*n -: 8] = mc[n];
    end
    case (op)
      RND_KEY:  s_out = s_in ^ rk;
      RND_FULL: s_out = mc_v ^ rk;
      RND_LAST: s_out = ss_v ^ rk;
      default:  s_out = s_in ^ rk;
    endcase
  end

endmodule

FILE: rtl/core/aes_block_encrypt_top.sv
// AES-128/192/256 block encryption core, one round per cycle.
// Depends on aes_pkg, aes_ksched and aes_round.
//
// Usage:
//   Configuration: write key_size (index 0) and the key words (index 1..4)
//   through cfg_valid/cfg_ready/cfg_index/cfg_data while the core is idle.
//   cfg_ready is always high. Size code 3 acts as a 256-bit key.
//   Input: a request is taken when start is high and busy is low; in_req
//   carries the plaintext block.
//   Output: out_strobe is high for one cycle with the ciphertext on out_res.
//   The receiver cannot stall; the result must be taken in that cycle.
// Operation:
//   The core runs the initial key add and the Nr rounds in the shared round unit,
//   one round per cycle, with the key schedule producing one round key per cycle
//   alongside. out_strobe rises at the same edge where busy falls. A new block
//   is accepted only once busy is low again, so blocks do not overlap in the core.
// Reset: rst_n (synchronous, active low) clears the key registers and size
//   to zero and returns the core to idle.
module aes_block_encrypt_top import aes_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  aes_in_t     in_req,
  output logic        out_strobe,
  output aes_out_t    out_res,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  aes_state_t  state_r, state_nxt;
  logic [1:0]  ksize_r;
  logic [63:0] kw_r [0:3];
  logic [3:0]  round_r, round_nxt;
  logic [127:0] s_r, s_nxt;
  logic        out_strobe_r, out_strobe_nxt;
  aes_out_t    out_res_r;
  logic [3:0]  nk, nr;
  logic [31:0] key_w [0:7];
  logic [127:0] rk, rnd_out;
  aes_rnd_op_t op;
  logic        accept, adv;

  assign cfg_ready = 1'b1;
  assign busy      = (state_r == ST_RUN);
  assign accept    = start && !busy;

  always_comb begin
    case (ksize_r)
      KS_128:  nk = 4'd4;
      KS_192:  nk = 4'd6;
      default: nk = 4'd8;
    endcase
    nr = nk + 4'd6;
    for (int k = 0; k < 4; k++) begin
      key_w[2*k]     = kw_r[k][63:32];
      key_w[2*k + 1] = kw_r[k][31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ksize_r <= KS_128;
      for (int k = 0; k < 4; k++) kw_r[k] <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_KEY_SIZE: ksize_r <= cfg_data[1:0];
        REG_KEY_W0:   kw_r[0] <= cfg_data;
        REG_KEY_W1:   kw_r[1] <= cfg_data;
        REG_KEY_W2:   kw_r[2] <= cfg_data;
        REG_KEY_W3:   kw_r[3] <= cfg_data;
        default:      ;
      endcase
    end
  end

  aes_ksched u_ksched (
    .clk   (clk),
    .rst_n (rst_n),
    .init  (accept),
    .adv   (adv),
    .nk    (nk),
    .key_w (key_w),
    .rk    (rk)
  );

  aes_round u_round (
    .op    (op),
    .s_in  (s_r),
    .rk    (rk),
    .s_out (rnd_out)
  );

  always_comb begin
    state_nxt      = state_r;
    round_nxt      = round_r;
    s_nxt          = s_r;
    out_strobe_nxt = 1'b0;
    adv            = 1'b0;
    op             = RND_KEY;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_RUN;
          round_nxt = '0;
          s_nxt     = in_req;
        end
      end
      ST_RUN: begin
        adv = 1'b1;
        if (round_r == 4'd0) op = RND_KEY;
        else if (round_r == nr) op = RND_LAST;
        else op = RND_FULL;
        s_nxt     = rnd_out;
        round_nxt = round_r + 4'd1;
        if (round_r == nr) begin
          // final round: hand the block to the output register
          out_strobe_nxt = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      round_r      <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      round_r      <= round_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s_r <= s_nxt;
    if (out_strobe_nxt) out_res_r <= rnd_out;
  end

  assign out_strobe = out_strobe_r;
  assign out_res    = out_res_r;

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy) else $error("request accepted but core not busy");
  a_strobe_after_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe_r |-> $past(busy)) else $error("strobe without a run");
  a_round_bound: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> round_r <= nr) else $error("round counter past last round");
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe_r |-> !busy) else $error("strobe while still busy");

endmodule

FILE: test/tb_aes_block_encrypt_top.sv
// Testbench for aes_block_encrypt_top: drives plaintext blocks and key writes,
// predicts ciphertext with an in-bench AES model. Depends on aes_pkg and the RTL.
`timescale 1ns / 1ps

module tb_aes_block_encrypt_top;
  import aes_pkg::*;

  localparam int CLK_HALF = 5;
  localparam int DRAIN_CYCLES = 40;
  localparam logic [2:0] REG_BAD = 3'd7;

  // Ciphertext predictor and store of expected blocks.
  class aes_cipher_board;
    logic [1:0]  size_code;
    logic [63:0] key_words [4];
    aes_out_t    pending [$];
    int          fail_count;

    function new();
      size_code = KS_128;
      foreach (key_words[i]) key_words[i] = '0;
      fail_count = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [63:0] val);
      case (idx)
        REG_KEY_SIZE: size_code = val[1:0];
        REG_KEY_W0:   key_words[0] = val;
        REG_KEY_W1:   key_words[1] = val;
        REG_KEY_W2:   key_words[2] = val;
        REG_KEY_W3:   key_words[3] = val;
        default: ;
      endcase
    endfunction

    static function logic [7:0] mul2(logic [7:0] b);
      return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
    endfunction

    static function logic [31:0] sbox_word(logic [31:0] w);
      return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

    function aes_out_t encrypt(aes_in_t blk);
      logic [31:0] rk [60];
      logic [7:0]  st [16];
      logic [7:0]  tmp [16];
      logic [31:0] t;
      logic [7:0]  rc, a0, a1, a2, a3, al;
      int nk, nr, sel;
      aes_out_t res;
      sel = (size_code > KS_256) ? 2 : int'(size_code);
      nk = 4 + 2 * sel;
      nr = nk + 6;
      rc = 8'h01;
      for (int i = 0; i < nk; i++)
        rk[i] = (i % 2 == 0) ? key_words[i/2][63:32] : key_words[i/2][31:0];
      for (int i = nk; i < 4 * (nr + 1); i++) begin
        t = rk[i-1];
        if (i % nk == 0) begin
          t = sbox_word({t[23:0], t[31:24]}) ^ {rc, 24'h0};
          rc = mul2(rc);
        end else if (nk > 6 && i % nk == 4) begin
          t = sbox_word(t);
        end
        rk[i] = rk[i-nk] ^ t;
      end
      for (int i = 0; i < 8; i++) begin
        st[i]   = blk.block_high[63-8*i -: 8];
        st[8+i] = blk.block_low[63-8*i -: 8];
      end
      for (int r = 0; r <= nr; r++) begin
        if (r > 0) begin
          for (int c = 0; c < 4; c++)
            for (int w = 0; w < 4; w++)
              tmp[4*c+w] = SBOX[st[4*((c+w)%4)+w]];
          st = tmp;
          if (r < nr) begin
            for (int c = 0; c < 4; c++) begin
              a0 = st[4*c]; a1 = st[4*c+1]; a2 = st[4*c+2]; a3 = st[4*c+3];
              al = a0 ^ a1 ^ a2 ^ a3;
              st[4*c]   = a0 ^ al ^ mul2(a0 ^ a1);
              st[4*c+1] = a1 ^ al ^ mul2(a1 ^ a2);
              st[4*c+2] = a2 ^ al ^ mul2(a2 ^ a3);
              st[4*c+3] = a3 ^ al ^ mul2(a3 ^ a0);
            end
          end
        end
        for (int c = 0; c < 4; c++)
          for (int b = 0; b < 4; b++)
            st[4*c+b] ^= rk[4*r+c][31-8*b -: 8];
      end
      for (int i = 0; i < 8; i++) begin
        res.cipher_high[63-8*i -: 8] = st[i];
        res.cipher_low[63-8*i -: 8]  = st[8+i];
      end
      return res;
    endfunction

    function void note_block(aes_in_t blk);
      pending.push_back(encrypt(blk));
    endfunction

    function void check_cipher(aes_out_t got);
      aes_out_t exp_res;
      if (pending.size() == 0) begin
        $error("unexpected ciphertext %h", got);
        fail_count++;
        return;
      end
      exp_res = pending.pop_front();
      if (got.cipher_high !== exp_res.cipher_high) begin
        $error("cipher_high: expected %h, got %h", exp_res.cipher_high, got.cipher_high);
        fail_count++;
      end
      if (got.cipher_low !== exp_res.cipher_low) begin
        $error("cipher_low: expected %h, got %h", exp_res.cipher_low, got.cipher_low);
        fail_count++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  aes_in_t     in_req;
  logic        out_strobe;
  aes_out_t    out_res;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [63:0] cfg_data;

  aes_cipher_board board;
  bit          calm_stretch;

  aes_block_encrypt_top dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_req(in_req),
    .out_strobe(out_strobe), .out_res(out_res), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && out_strobe) board.check_cipher(out_res);
  end

  task automatic write_cfg(logic [2:0] idx, logic [63:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    board.write_reg(idx, val);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_block(aes_in_t blk);
    if (!calm_stretch) begin
      while ($urandom_range(99) < 31) @(posedge clk);
    end
    start  <= 1'b1;
    in_req <= blk;
    do @(posedge clk); while (busy);
    board.note_block(blk);
    start <= 1'b0;
    // the core is busy on the next edge anyway
    @(posedge clk);
  endtask

  // Wait for all ciphertext, then for the DRAIN_CYCLES drain period so the core is surely idle.
  task automatic drain();
    while (board.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic load_key(logic [1:0] sz, logic [63:0] k0, logic [63:0] k1,
                          logic [63:0] k2, logic [63:0] k3);
    write_cfg(REG_KEY_SIZE, {62'h0, sz});
    write_cfg(REG_KEY_W0, k0);
    write_cfg(REG_KEY_W1, k1);
    write_cfg(REG_KEY_W2, k2);
    write_cfg(REG_KEY_W3, k3);
  endtask

  initial begin
    aes_in_t blk;
    board = new();
    rst_n = 1'b0; start = 1'b0; in_req = '0;
    cfg_valid = 1'b0; cfg_index = REG_KEY_SIZE; cfg_data = '0;
    calm_stretch = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset key (all zero, 128-bit) and extreme plaintexts.
    send_block('0);
    send_block('1);
    drain();

    // Known-answer vectors for each key size, plus size code 3.
    load_key(KS_128, 64'h0001020304050607, 64'h08090a0b0c0d0e0f, '1, '1);
    send_block({64'h0011223344556677, 64'h8899aabbccddeeff});
    drain();
    load_key(KS_192, 64'h0001020304050607, 64'h08090a0b0c0d0e0f,
             64'h1011121314151617, '1);
    send_block({64'h0011223344556677, 64'h8899aabbccddeeff});
    drain();
    load_key(KS_256, 64'h0001020304050607, 64'h08090a0b0c0d0e0f,
             64'h1011121314151617, 64'h18191a1b1c1d1e1f);
    send_block({64'h0011223344556677, 64'h8899aabbccddeeff});
    send_block('0);
    drain();
    write_cfg(REG_KEY_SIZE, 64'h3);
    send_block({64'h0011223344556677, 64'h8899aabbccddeeff});
    drain();
    // Out-of-range index must be ignored.
    write_cfg(REG_BAD, '1);
    load_key(KS_256, '1, '1, '1, '1);
    send_block('1);
    send_block({64'h8000000000000000, 64'h0000000000000001});
    drain();

    // Random phases: fresh key each phase, random size including code 3.
    for (int ph = 0; ph < 16; ph++) begin
      load_key(2'($urandom_range(3)), rand64(), rand64(), rand64(), rand64());
      calm_stretch = (ph == 5);
      for (int n = 0; n < 100; n++) begin
        blk.block_high = rand64();
        blk.block_low  = rand64();
        send_block(blk);
        // Hold off until every pending block has come out.
        if (n == 50) begin
          while (board.pending.size() != 0) @(posedge clk);
        end
      end
      drain();
    end

    drain();
    if (board.fail_count == 0 && board.pending.size() == 0)
      $display("tb_aes_block_encrypt_top passed");
    else
      $display("tb_aes_block_encrypt_top failed");
    $finish;
  end

  initial begin
    #3_000_000;
    $display("tb_aes_block_encrypt_top failed");
    $finish;
  end

endmodule
